### hdl/stre_pkg.sv
// Shared definitions for the square tile rotate engine: grid geometry,
// item field widths, operation codes and the sequencer state type.
// Stands alone; used by the top level of the engine and by the bench.
`default_nettype none

package stre_pkg;

  // Grid geometry and cell width
  localparam int unsigned GRID_SIDE = 32;
  localparam int unsigned CELL_BITS = 8;
  localparam int unsigned CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ROW_W     = $clog2(GRID_SIDE);
  localparam int unsigned ADDR_W    = $clog2(CELLS);

  // Item field widths, fixed by the stream format
  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SIDE_W  = 6;
  localparam int unsigned VAL_W   = 8;
  // Width for row/column sums that may run past the grid
  localparam int unsigned SUM_W   = SIDE_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_ROTATE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROT,
    ST_FLUSH_C,
    ST_FLUSH_D
  } state_e;

  // Linear cell address of (row, col)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(GRID_SIDE) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

### hdl/stre_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk_i,
  input  wire                     wr_en_i,
  input  wire [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire [WIDTH-1:0]         wr_data_i,
  input  wire [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write when enabled, read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

### hdl/square_tile_rotate_engine.sv
// Top level of the square tile rotate engine: stream ports, sequencer and
// one cell RAM. Depends on stre_pkg and stre_ram.
`default_nettype none

// Holds a 32 x 32 grid of 8-bit cells in one RAM and answers every input
// word with exactly one output word. A write is done when the word is taken,
// a read answers from the read state. A rotate turns the block clockwise in
// groups of four cells, floor(s/2)*ceil(s/2) groups for side s, and drains
// the last writes in the flush states. Its pace is set by the single read
// port of the cell RAM, which fetches one cell per cycle. Rejected items and
// sides of 0 or 1 answer straight from the idle state. A new word is taken
// only while no item is in progress. Cells that were never written read back
// as whatever the RAM holds.
module square_tile_rotate_engine (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // row[4:0], col[9:5], side[15:10], write_value[23:16]
  input  wire  [23:0] s_axis_tdata,
  // operation[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // read_value[7:0]
  output logic [7:0]  m_axis_tdata,
  // status[0]
  output logic        m_axis_tuser
);

  localparam int unsigned ROW_W  = stre_pkg::ROW_W;
  localparam int unsigned ADDR_W = stre_pkg::ADDR_W;
  localparam int unsigned SIDE_W = stre_pkg::SIDE_W;
  localparam int unsigned SUM_W  = stre_pkg::SUM_W;
  localparam int unsigned CELL_W = stre_pkg::CELL_BITS;
  localparam int unsigned VAL_W  = stre_pkg::VAL_W;

  stre_pkg::state_e state_q, state_d;

  logic [1:0]        step_q, step_d;
  logic [ROW_W-1:0]  i_q, i_d, j_q, j_d, y_q, y_d, x_q, x_d;
  logic [SIDE_W-1:0] s_q, s_d;
  logic              prev_vld_q, prev_vld_d;
  logic [CELL_W-1:0] a_hold_q, a_hold_d;
  logic [ADDR_W-1:0] c_prev_q, c_prev_d, d_prev_q, d_prev_d;
  logic              out_vld_q, out_vld_d;
  logic [VAL_W-1:0]  out_data_q, out_data_d;
  logic              out_status_q, out_status_d;

  // Input word fields
  logic [1:0]        in_op;
  logic [4:0]        in_row, in_col;
  logic [SIDE_W-1:0] in_side;
  logic [VAL_W-1:0]  in_value;
  logic              in_fire, in_cell_ok, in_rot_ok;
  logic [ADDR_W-1:0] in_addr;

  assign in_op    = s_axis_tuser;
  assign in_row   = s_axis_tdata[4:0];
  assign in_col   = s_axis_tdata[9:5];
  assign in_side  = s_axis_tdata[15:10];
  assign in_value = s_axis_tdata[23:16];

  assign in_cell_ok = (SUM_W'(in_row) < SUM_W'(stre_pkg::GRID_SIDE)) &&
                      (SUM_W'(in_col) < SUM_W'(stre_pkg::GRID_SIDE));
  assign in_rot_ok  = (SUM_W'(in_row) + SUM_W'(in_side) <= SUM_W'(stre_pkg::GRID_SIDE)) &&
                      (SUM_W'(in_col) + SUM_W'(in_side) <= SUM_W'(stre_pkg::GRID_SIDE));
  assign in_addr    = stre_pkg::cell_addr(ROW_W'(in_row), ROW_W'(in_col));

  assign s_axis_tready = (state_q == stre_pkg::ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // Corner cells of the current group of four
  logic [SIDE_W-1:0] s_m1, lo_last, hi_last;
  logic [SUM_W-1:0]  row_a, col_a, row_b, col_b, row_c, col_c, row_d, col_d;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_c, addr_d;

  assign s_m1    = s_q - SIDE_W'(1);
  assign lo_last = (s_q >> 1) - SIDE_W'(1);
  assign hi_last = SIDE_W'((SUM_W'(s_q) + SUM_W'(1)) >> 1) - SIDE_W'(1);

  assign row_a = SUM_W'(y_q) + SUM_W'(i_q);
  assign col_a = SUM_W'(x_q) + SUM_W'(j_q);
  assign row_b = SUM_W'(y_q) + SUM_W'(s_m1) - SUM_W'(j_q);
  assign col_b = SUM_W'(x_q) + SUM_W'(i_q);
  assign row_c = SUM_W'(y_q) + SUM_W'(s_m1) - SUM_W'(i_q);
  assign col_c = SUM_W'(x_q) + SUM_W'(s_m1) - SUM_W'(j_q);
  assign row_d = SUM_W'(y_q) + SUM_W'(j_q);
  assign col_d = SUM_W'(x_q) + SUM_W'(s_m1) - SUM_W'(i_q);

  assign addr_a = stre_pkg::cell_addr(row_a[ROW_W-1:0], col_a[ROW_W-1:0]);
  assign addr_b = stre_pkg::cell_addr(row_b[ROW_W-1:0], col_b[ROW_W-1:0]);
  assign addr_c = stre_pkg::cell_addr(row_c[ROW_W-1:0], col_c[ROW_W-1:0]);
  assign addr_d = stre_pkg::cell_addr(row_d[ROW_W-1:0], col_d[ROW_W-1:0]);

  // Cell RAM
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  stre_ram #(
    .WIDTH (CELL_W),
    .DEPTH (stre_pkg::CELLS)
  ) u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer: reads of a group overlap the last writes of the previous group
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    i_d          = i_q;
    j_d          = j_q;
    y_d          = y_q;
    x_d          = x_q;
    s_d          = s_q;
    prev_vld_d   = prev_vld_q;
    a_hold_d     = a_hold_q;
    c_prev_d     = c_prev_q;
    d_prev_d     = d_prev_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = addr_a;
    wr_data      = rd_data;
    rd_addr      = in_addr;

    unique case (state_q)
      stre_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_data_d   = '0;
          out_status_d = 1'b0;
          unique case (stre_pkg::op_e'(in_op))
            stre_pkg::OP_WRITE: begin
              out_vld_d = 1'b1;
              if (in_cell_ok) begin
                wr_en   = 1'b1;
                wr_addr = in_addr;
                wr_data = CELL_W'(in_value);
              end else begin
                out_status_d = 1'b1;
              end
            end
            stre_pkg::OP_READ: begin
              if (in_cell_ok) begin
                state_d = stre_pkg::ST_READ;
              end else begin
                out_vld_d    = 1'b1;
                out_status_d = 1'b1;
              end
            end
            stre_pkg::OP_ROTATE: begin
              if (!in_rot_ok) begin
                out_vld_d    = 1'b1;
                out_status_d = 1'b1;
              end else if (in_side < SIDE_W'(2)) begin
                out_vld_d = 1'b1;
              end else begin
                y_d        = ROW_W'(in_row);
                x_d        = ROW_W'(in_col);
                s_d        = in_side;
                i_d        = '0;
                j_d        = '0;
                step_d     = '0;
                prev_vld_d = 1'b0;
                state_d    = stre_pkg::ST_ROT;
              end
            end
            default: begin
              out_vld_d    = 1'b1;
              out_status_d = 1'b1;
            end
          endcase
        end
      end

      stre_pkg::ST_READ: begin
        out_vld_d    = 1'b1;
        out_data_d   = VAL_W'(rd_data);
        out_status_d = 1'b0;
        state_d      = stre_pkg::ST_IDLE;
      end

      stre_pkg::ST_ROT: begin
        step_d = step_q + 2'd1;
        unique case (step_q)
          2'd0: begin
            // read a; previous group's d data arrives, store it into c
            rd_addr = addr_a;
            wr_en   = prev_vld_q;
            wr_addr = c_prev_q;
          end
          2'd1: begin
            // read b; hold a; previous group's held a goes into d
            rd_addr  = addr_b;
            a_hold_d = rd_data;
            wr_en    = prev_vld_q;
            wr_addr  = d_prev_q;
            wr_data  = a_hold_q;
          end
          2'd2: begin
            // read c; b data goes into a
            rd_addr = addr_c;
            wr_en   = 1'b1;
            wr_addr = addr_a;
          end
          2'd3: begin
            // read d; c data goes into b; advance to the next group
            rd_addr    = addr_d;
            wr_en      = 1'b1;
            wr_addr    = addr_b;
            c_prev_d   = addr_c;
            d_prev_d   = addr_d;
            prev_vld_d = 1'b1;
            if (SIDE_W'(j_q) == hi_last) begin
              j_d = '0;
              if (SIDE_W'(i_q) == lo_last) begin
                state_d = stre_pkg::ST_FLUSH_C;
              end else begin
                i_d = i_q + ROW_W'(1);
              end
            end else begin
              j_d = j_q + ROW_W'(1);
            end
          end
          default: begin
            rd_addr = addr_a;
          end
        endcase
      end

      stre_pkg::ST_FLUSH_C: begin
        // last d data goes into c
        wr_en   = 1'b1;
        wr_addr = c_prev_q;
        state_d = stre_pkg::ST_FLUSH_D;
      end

      stre_pkg::ST_FLUSH_D: begin
        // last held a goes into d; report done
        wr_en        = 1'b1;
        wr_addr      = d_prev_q;
        wr_data      = a_hold_q;
        out_vld_d    = 1'b1;
        out_data_d   = '0;
        out_status_d = 1'b0;
        state_d      = stre_pkg::ST_IDLE;
      end

      default: begin
        state_d = stre_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stre_pkg::ST_IDLE;
      step_q     <= '0;
      prev_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      prev_vld_q <= prev_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    y_q          <= y_d;
    x_q          <= x_d;
    s_q          <= s_d;
    a_hold_q     <= a_hold_d;
    c_prev_q     <= c_prev_d;
    d_prev_q     <= d_prev_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for square_tile_rotate_engine: cell writes, reads and
// block rotates, checked word by word against an in-bench grid predictor.
// Depends on stre_pkg and the engine RTL only.
module tb;

  localparam int          GRID_SIDE    = int'(stre_pkg::GRID_SIDE);
  localparam int          CELLS        = int'(stre_pkg::CELLS);
  localparam int unsigned CELL_BITS    = stre_pkg::CELL_BITS;
  localparam int unsigned OP_W         = stre_pkg::OP_W;
  localparam int unsigned POS_W        = stre_pkg::POS_W;
  localparam int unsigned SIDE_W       = stre_pkg::SIDE_W;
  localparam int unsigned VAL_W        = stre_pkg::VAL_W;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam logic            STAT_DONE    = 1'b0;
  localparam logic            STAT_IGNORED = 1'b1;
  localparam int unsigned     CYCLE_LIMIT  = 600000;
  localparam int unsigned     PHASE_WORDS  = 140;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SIDE_W-1:0] side;
    logic [VAL_W-1:0]  wval;
  } grid_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } grid_reply_t;

  typedef struct packed {
    grid_word_t  word;
    logic        typed;
    grid_reply_t reply;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 24;

  // Directed table: typed replies where obvious, the rest from the predictor
  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{'{stre_pkg::OP_WRITE,  5'd0,  5'd0,  6'd0,  8'h00}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_WRITE,  5'd31, 5'd31, 6'd63, 8'hFF}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_WRITE,  5'd0,  5'd31, 6'd0,  8'hA5}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_WRITE,  5'd31, 5'd0,  6'd0,  8'h5A}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_READ,   5'd31, 5'd31, 6'd0,  8'h00}, 1'b1, '{8'hFF, STAT_DONE}},
    '{'{stre_pkg::OP_READ,   5'd0,  5'd0,  6'd63, 8'hFF}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{OP_UNUSED,           5'd31, 5'd31, 6'd63, 8'hFF}, 1'b1, '{8'h00, STAT_IGNORED}},
    '{'{stre_pkg::OP_ROTATE, 5'd1,  5'd0,  6'd32, 8'h00}, 1'b1, '{8'h00, STAT_IGNORED}},
    '{'{stre_pkg::OP_ROTATE, 5'd0,  5'd31, 6'd2,  8'h00}, 1'b1, '{8'h00, STAT_IGNORED}},
    '{'{stre_pkg::OP_ROTATE, 5'd0,  5'd0,  6'd63, 8'h00}, 1'b1, '{8'h00, STAT_IGNORED}},
    '{'{stre_pkg::OP_ROTATE, 5'd31, 5'd31, 6'd0,  8'h00}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_ROTATE, 5'd31, 5'd31, 6'd1,  8'h00}, 1'b1, '{8'h00, STAT_DONE}},
    '{'{stre_pkg::OP_WRITE,  5'd10, 5'd10, 6'd0,  8'h01}, 1'b0, '0},
    '{'{stre_pkg::OP_WRITE,  5'd10, 5'd11, 6'd0,  8'h02}, 1'b0, '0},
    '{'{stre_pkg::OP_WRITE,  5'd11, 5'd10, 6'd0,  8'h03}, 1'b0, '0},
    '{'{stre_pkg::OP_WRITE,  5'd11, 5'd11, 6'd0,  8'h04}, 1'b0, '0},
    '{'{stre_pkg::OP_ROTATE, 5'd10, 5'd10, 6'd2,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_READ,   5'd10, 5'd10, 6'd0,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_READ,   5'd11, 5'd11, 6'd0,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_ROTATE, 5'd9,  5'd9,  6'd3,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_READ,   5'd10, 5'd9,  6'd0,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_ROTATE, 5'd0,  5'd0,  6'd32, 8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_READ,   5'd0,  5'd31, 6'd0,  8'h00}, 1'b0, '0},
    '{'{stre_pkg::OP_READ,   5'd31, 5'd0,  6'd0,  8'h00}, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // row[4:0], col[9:5], side[15:10], write_value[23:16]
  logic [23:0]       s_axis_tdata;
  // operation[1:0]
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // read_value[7:0]
  logic [7:0]        m_axis_tdata;
  // status[0]
  logic              m_axis_tuser;

  // Predicted grid contents, and which cells hold a written value
  logic [CELL_BITS-1:0] grid_val [CELLS];
  bit                   grid_set [CELLS];

  grid_reply_t expected_replies [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  square_tile_rotate_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Turn the block at (r0, c0) of side s clockwise: new (r, c) takes old (s-1-c, r)
  function automatic void grid_turn_clockwise(int r0, int c0, int s);
    logic [CELL_BITS-1:0] blk_val [GRID_SIDE][GRID_SIDE];
    bit                   blk_set [GRID_SIDE][GRID_SIDE];
    for (int r = 0; r < s; r++)
      for (int c = 0; c < s; c++) begin
        blk_val[r][c] = grid_val[(r0 + r) * GRID_SIDE + c0 + c];
        blk_set[r][c] = grid_set[(r0 + r) * GRID_SIDE + c0 + c];
      end
    for (int r = 0; r < s; r++)
      for (int c = 0; c < s; c++) begin
        grid_val[(r0 + r) * GRID_SIDE + c0 + c] = blk_val[s - 1 - c][r];
        grid_set[(r0 + r) * GRID_SIDE + c0 + c] = blk_set[s - 1 - c][r];
      end
  endfunction

  // Apply one word to the predicted grid and return the reply it should get
  function automatic grid_reply_t grid_apply_word(grid_word_t w);
    grid_reply_t rep;
    int          idx;
    rep = '{8'h00, STAT_DONE};
    idx = int'(w.row) * GRID_SIDE + int'(w.col);
    case (w.op)
      stre_pkg::OP_WRITE, stre_pkg::OP_READ: begin
        if (int'(w.row) >= GRID_SIDE || int'(w.col) >= GRID_SIDE) begin
          rep.status = STAT_IGNORED;
        end else if (w.op == stre_pkg::OP_WRITE) begin
          grid_val[idx] = w.wval[CELL_BITS-1:0];
          grid_set[idx] = 1'b1;
        end else begin
          rep.read_value = VAL_W'(grid_val[idx]);
        end
      end
      stre_pkg::OP_ROTATE: begin
        if (int'(w.row) + int'(w.side) > GRID_SIDE ||
            int'(w.col) + int'(w.side) > GRID_SIDE) begin
          rep.status = STAT_IGNORED;
        end else if (w.side >= SIDE_W'(2)) begin
          grid_turn_clockwise(int'(w.row), int'(w.col), int'(w.side));
        end
      end
      default: rep.status = STAT_IGNORED;
    endcase
    return rep;
  endfunction

  // Build one random word; reads go only to cells that hold a written value
  function automatic grid_word_t make_random_word();
    grid_word_t  w;
    int unsigned pick;
    int unsigned sz;
    bit          found;
    w.op   = OP_W'($urandom);
    w.row  = POS_W'($urandom);
    w.col  = POS_W'($urandom);
    w.side = SIDE_W'($urandom);
    w.wval = VAL_W'($urandom);
    pick = $urandom_range(99);
    found = 1'b0;
    if (pick < 30) begin
      for (int k = 0; k < 64 && !found; k++) begin
        w.row = POS_W'($urandom_range(GRID_SIDE - 1));
        w.col = POS_W'($urandom_range(GRID_SIDE - 1));
        found = grid_set[int'(w.row) * GRID_SIDE + int'(w.col)];
      end
    end
    if (pick < 30 && found) begin
      w.op = stre_pkg::OP_READ;
    end else if (pick < 65) begin
      w.op = stre_pkg::OP_WRITE;
    end else if (pick < 90) begin
      // Valid rotate: mostly small blocks, a few large ones, rare trivial sides
      w.op = stre_pkg::OP_ROTATE;
      if ($urandom_range(99) < 3)
        sz = $urandom_range(9, GRID_SIDE);
      else if ($urandom_range(99) < 5)
        sz = $urandom_range(1);
      else
        sz = $urandom_range(2, 8);
      w.side = SIDE_W'(sz);
      w.row = POS_W'($urandom_range(GRID_SIDE - sz));
      w.col = POS_W'($urandom_range(GRID_SIDE - sz));
    end else if (pick < 97) begin
      // Rotate that runs past the grid edge
      w.op = stre_pkg::OP_ROTATE;
      do begin
        w.side = SIDE_W'($urandom_range(63));
        w.row = POS_W'($urandom_range(GRID_SIDE - 1));
        w.col = POS_W'($urandom_range(GRID_SIDE - 1));
      end while (int'(w.row) + int'(w.side) <= GRID_SIDE &&
                 int'(w.col) + int'(w.side) <= GRID_SIDE);
    end else begin
      w.op = OP_UNUSED;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one word with random idle cycles, then predict once it is taken
  task automatic send_word(input grid_word_t w, input logic typed, input grid_reply_t want);
    grid_reply_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.wval, w.side, w.col, w.row};
    s_axis_tuser  <= w.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = grid_apply_word(w);
    expected_replies.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every pending reply has come back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // Stall the receiver at random and check each reply word
  always @(posedge clk_i) begin
    grid_reply_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply word with nothing expected");
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata !== want.read_value)
          report_mismatch($sformatf("read_value %0h, expected %0h",
                                    m_axis_tdata, want.read_value));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b",
                                    m_axis_tuser, want.status));
      end
    end
  end

  initial begin
    int unsigned phase_idle  [4] = '{0, 73, 0, 12};
    int unsigned phase_stall [4] = '{0, 0, 73, 12};
    for (int i = 0; i < CELLS; i++) begin
      grid_val[i] = '0;
      grid_set[i] = 1'b0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with no idling
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);
    drain_replies();

    // Random words in phases of sender idling and receiver stalls, draining midway and between them
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(make_random_word(), 1'b0, '0);
        if (n == PHASE_WORDS / 2)
          drain_replies();
      end
      drain_replies();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/stre_pkg.sv
hdl/stre_ram.sv
hdl/square_tile_rotate_engine.sv
test/tb.sv
